### hw/rtl/additive_square_voice_with_adsr_top_defines.svh
// Assertion macros shared by the voice RTL.
`ifndef ADDITIVE_SQUARE_VOICE_WITH_ADSR_TOP_DEFINES_SVH
`define ADDITIVE_SQUARE_VOICE_WITH_ADSR_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define ASV_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define ASV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/asvadsr_pkg.sv
// Package: constants, types and constant tables of the additive voice.
`default_nettype none

package asvadsr_pkg;

  localparam int HARMONICS       = 50;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SAMPLE_BITS     = 16;

  // odd harmonics 1, 3, ... up to HARMONICS
  localparam int NUM_HARM = (HARMONICS + 1) / 2;
  localparam int HIDX_W   = $clog2(NUM_HARM + 1);
  localparam int AIDX_W   = (NUM_HARM > 1) ? $clog2(NUM_HARM) : 1;

  localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
  localparam int SADDR_W = SINE_TABLE_BITS - 1;
  localparam int SMAG_W  = 15;
  localparam int AMP_W   = 17;

  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 25;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 34;

  localparam logic [23:0] CURVE_ONE = 24'hFFFFFF;
  localparam logic [24:0] ENV_ONE   = 25'h1000000;
  localparam logic [15:0] SUS_FULL  = 16'd32768;
  localparam logic [14:0] FS        = 15'((1 << (SAMPLE_BITS - 1)) - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_ENV_MUL,
    S_ENV_SET,
    S_CURVE_SET,
    S_HARM,
    S_ABS,
    S_SCALE_MUL,
    S_SCALE_SET,
    S_FS_MUL,
    S_FS_SET,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    SEG_ATTACK,
    SEG_DECAY,
    SEG_RELEASE
  } seg_t;

  typedef enum logic [2:0] {
    CFG_PHASE_STEP     = 3'd0,
    CFG_ATTACK_SAMPLES = 3'd1,
    CFG_ATTACK_FACTOR  = 3'd2,
    CFG_DECAY_FACTOR   = 3'd3,
    CFG_SUSTAIN_LEVEL  = 3'd4,
    CFG_GATE_SAMPLES   = 3'd5,
    CFG_RELEASE_FACTOR = 3'd6,
    CFG_NOTE_SAMPLES   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic              neg;
    logic [SMAG_W-1:0] mag;
  } sine_t;

  typedef logic [SMAG_W-1:0] sine_rom_t [QUARTER+1];
  typedef logic [AMP_W-1:0]  amp_rom_t  [NUM_HARM];

  // Q1.15 quarter sine from a Q28 odd polynomial in nested form
  function automatic logic [SMAG_W-1:0] quarter_sine(input int unsigned i);
    logic [63:0] u;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    u  = 64'(i) << (28 - (SINE_TABLE_BITS - 2));
    x  = (u * 64'd421657428) >> 28;
    x2 = (x * x) >> 28;
    t  = 64'd268435456 - x2 / 64'd110;
    t  = 64'd268435456 - ((x2 * t) >> 28) / 64'd72;
    t  = 64'd268435456 - ((x2 * t) >> 28) / 64'd42;
    t  = 64'd268435456 - ((x2 * t) >> 28) / 64'd20;
    t  = 64'd268435456 - ((x2 * t) >> 28) / 64'd6;
    s  = (x * t) >> 28;
    s  = (s * 64'd32767 + 64'd134217728) >> 28;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[SMAG_W-1:0];
  endfunction

  function automatic sine_rom_t build_sine();
    sine_rom_t r;
    for (int i = 0; i <= QUARTER; i++) begin
      r[i] = quarter_sine(i);
    end
    return r;
  endfunction

  // shift-and-subtract long division, used only to build the constant tables
  function automatic logic [63:0] const_div(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Q0.16 weights proportional to 1/k, normalized to sum to one
  function automatic amp_rom_t build_amp();
    amp_rom_t    r;
    logic [63:0] h;
    logic [63:0] q;
    h = '0;
    for (int j = 0; j < NUM_HARM; j++) begin
      h = h + const_div(64'd1 << 32, 64'(2 * j + 1));
    end
    if (h == 64'd0) begin
      h = 64'd1;
    end
    for (int j = 0; j < NUM_HARM; j++) begin
      q    = const_div(64'd1 << 32, 64'(2 * j + 1));
      r[j] = AMP_W'(const_div((q << 16) + (h >> 1), h));
    end
    return r;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();
  localparam amp_rom_t  AMP_ROM  = build_amp();

endpackage

`default_nettype wire

### hw/rtl/asvadsr_mul.sv
// Shared unsigned multiplier with registered product.
`default_nettype none

module asvadsr_mul (
  input  wire logic                           clk,
  input  wire logic [asvadsr_pkg::MUL_A_W-1:0] a,
  input  wire logic [asvadsr_pkg::MUL_B_W-1:0] b,
  output logic      [asvadsr_pkg::MUL_P_W-1:0] p
);
  import asvadsr_pkg::*;

  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

`default_nettype wire

### hw/rtl/asvadsr_sine.sv
// Quarter-wave sine lookup with registered magnitude and sign.
`default_nettype none

module asvadsr_sine (
  input  wire logic        clk,
  input  wire logic        load,
  input  wire logic [31:0] ph,
  output asvadsr_pkg::sine_t sine
);
  import asvadsr_pkg::*;

  logic [SINE_TABLE_BITS-1:0] idx;
  logic [1:0]                 quad;
  logic [SADDR_W-1:0]         offs;
  logic [SADDR_W-1:0]         addr;

  always_comb begin
    idx  = ph[31 -: SINE_TABLE_BITS];
    quad = idx[SINE_TABLE_BITS-1 -: 2];
    offs = {1'b0, idx[SINE_TABLE_BITS-3:0]};
    // mirror the table in the second and fourth quadrants
    addr = quad[0] ? (SADDR_W'(QUARTER) - offs) : offs;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sine.mag <= SINE_ROM[addr];
      sine.neg <= quad[1];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/additive_square_voice_with_adsr_top.sv
// Top level: additive square voice with exponential ADSR envelope.
// Sequence: a sounding tick runs the envelope states, a harmonic loop with one
//   pass per odd harmonic through the multiplier, then the scaling states; a tick
//   past note end goes straight to the result. A new tick is taken only once the
//   previous result is registered and the sequencer is back in idle.
// Reset: synchronous, active high; config registers take their defaults,
//   count and phase clear, every envelope curve goes to one.
`default_nettype none

`include "additive_square_voice_with_adsr_top_defines.svh"

module additive_square_voice_with_adsr_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // tick request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        restart,
  // sample result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [15:0] sample,
  output logic             done_res,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import asvadsr_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0] phase_step;
  logic [23:0] attack_samples;
  logic [23:0] attack_factor;
  logic [23:0] decay_factor;
  logic [15:0] sustain_level;
  logic [23:0] gate_samples;
  logic [23:0] release_factor;
  logic [23:0] note_samples;

  // The user must write only while the voice is idle; the block does not enforce it and always takes writes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step     <= 32'd39370534;
      attack_samples <= 24'd480;
      attack_factor  <= 24'd16603360;
      decay_factor   <= 24'd16765569;
      sustain_level  <= 16'd16384;
      gate_samples   <= 24'd33600;
      release_factor <= 24'd16771392;
      note_samples   <= 24'd48000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PHASE_STEP:     phase_step     <= cfg_data;
        CFG_ATTACK_SAMPLES: attack_samples <= cfg_data[23:0];
        CFG_ATTACK_FACTOR:  attack_factor  <= cfg_data[23:0];
        CFG_DECAY_FACTOR:   decay_factor   <= cfg_data[23:0];
        CFG_SUSTAIN_LEVEL:  sustain_level  <= cfg_data[15:0];
        CFG_GATE_SAMPLES:   gate_samples   <= cfg_data[23:0];
        CFG_RELEASE_FACTOR: release_factor <= cfg_data[23:0];
        CFG_NOTE_SAMPLES:   note_samples   <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Voice state, sequencer and datapath registers
  // ---------------------------------------------------------------------------
  state_t state, state_next;

  logic [23:0] sample_count;
  logic [31:0] phase;
  logic [23:0] attack_curve;
  logic [23:0] decay_curve;
  logic [23:0] release_curve;

  seg_t        seg;
  logic        over;
  logic [24:0] env;

  logic [31:0]       ph_acc;
  logic [31:0]       ph_two;
  logic [HIDX_W-1:0] hidx;
  logic [AMP_W-1:0]  s1_amp;
  logic              s1_v;
  logic              p_v;
  logic              p_neg;
  logic signed [ACC_W-1:0] acc;

  logic        neg;
  logic [31:0] mag;
  logic [31:0] mag2;
  logic [15:0] res_sample;

  // shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  sine_t              sine;

  // ---------------------------------------------------------------------------
  // Derived values
  // ---------------------------------------------------------------------------
  logic        accept;
  logic        out_free;
  logic        note_over;
  logic        rd;
  logic        sine_load;
  logic [24:0] s24;
  logic [MUL_P_W-1:0] sum24;
  logic [MUL_P_W-1:0] sum31;
  logic [MUL_P_W-25:0] rnd24;
  logic [MUL_P_W-32:0] rnd31;
  logic [15:0] sat_sample;

  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign note_over = (sample_count >= note_samples);
  // more harmonics left to fetch
  assign rd        = (hidx < HIDX_W'(NUM_HARM));
  assign sine_load = (state == S_HARM) && rd;

  // Sustain above full scale clamps to full scale; Q1.15 -> Q1.24.
  assign s24 = (sustain_level > SUS_FULL) ? ENV_ONE : {sustain_level, 9'd0};

  // round-to-nearest shifts of the product
  assign sum24 = mul_p + (MUL_P_W'(1) << 23);
  assign sum31 = mul_p + (MUL_P_W'(1) << 30);
  assign rnd24 = sum24[MUL_P_W-1:24];
  assign rnd31 = sum31[MUL_P_W-1:31];

  // Clip the rounded magnitude and apply the sign.
  always_comb begin
    if (neg) begin
      sat_sample = (rnd31 > 26'd32768) ? 16'h8000 : (16'd0 - rnd31[15:0]);
    end else begin
      sat_sample = (rnd31 > 26'd32767) ? 16'h7FFF : rnd31[15:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (accept) state_next = S_CHECK;
      S_CHECK:     state_next = note_over ? S_FIN : S_ENV_MUL;
      S_ENV_MUL:   state_next = S_ENV_SET;
      S_ENV_SET:   state_next = S_CURVE_SET;
      S_CURVE_SET: state_next = S_HARM;
      S_HARM:      if (!rd && !s1_v && !p_v) state_next = S_ABS;
      S_ABS:       state_next = S_SCALE_MUL;
      S_SCALE_MUL: state_next = S_SCALE_SET;
      S_SCALE_SET: state_next = S_FS_MUL;
      S_FS_MUL:    state_next = S_FS_SET;
      S_FS_SET:    state_next = S_FIN;
      S_FIN:       if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs (handshake and multiplier operand steering)
  // ---------------------------------------------------------------------------
  always_comb begin
    in_stall = (state != S_IDLE);
    mul_a    = '0;
    mul_b    = '0;
    case (state)
      // envelope value for the decay and release segments
      S_ENV_MUL: begin
        case (seg)
          SEG_DECAY: begin
            mul_a = MUL_A_W'(ENV_ONE - s24);
            mul_b = MUL_B_W'(decay_curve);
          end
          SEG_RELEASE: begin
            mul_a = MUL_A_W'(s24);
            mul_b = MUL_B_W'(release_curve);
          end
          default: ;
        endcase
      end
      // advance the curve of the active segment
      S_ENV_SET: begin
        case (seg)
          SEG_ATTACK: begin
            mul_a = MUL_A_W'(attack_curve);
            mul_b = MUL_B_W'(attack_factor);
          end
          SEG_DECAY: begin
            mul_a = MUL_A_W'(decay_curve);
            mul_b = MUL_B_W'(decay_factor);
          end
          SEG_RELEASE: begin
            mul_a = MUL_A_W'(release_curve);
            mul_b = MUL_B_W'(release_factor);
          end
          default: ;
        endcase
      end
      // weight times sine magnitude, one harmonic per cycle
      S_HARM: begin
        mul_a = MUL_A_W'(s1_amp);
        mul_b = MUL_B_W'(sine.mag);
      end
      S_SCALE_MUL: begin
        mul_a = mag;
        mul_b = env;
      end
      S_FS_MUL: begin
        mul_a = mag2;
        mul_b = MUL_B_W'(FS);
      end
      default: ;
    endcase
  end

  asvadsr_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  asvadsr_sine u_sine (
    .clk  (clk),
    .load (sine_load),
    .ph   (ph_acc),
    .sine (sine)
  );

  // ---------------------------------------------------------------------------
  // Voice state: count, phase and envelope curves
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count  <= '0;
      phase         <= '0;
      attack_curve  <= CURVE_ONE;
      decay_curve   <= CURVE_ONE;
      release_curve <= CURVE_ONE;
    end else begin
      // restart takes effect before this tick is computed
      if (accept && restart) begin
        sample_count  <= '0;
        phase         <= '0;
        attack_curve  <= CURVE_ONE;
        decay_curve   <= CURVE_ONE;
        release_curve <= CURVE_ONE;
      end
      // advance count and phase only while the note sounds; hold after it
      if (state == S_CHECK && !note_over) begin
        sample_count <= sample_count + 24'd1;
        phase        <= phase + phase_step;
      end
      if (state == S_CURVE_SET) begin
        case (seg)
          SEG_ATTACK:  attack_curve  <= rnd24[23:0];
          SEG_DECAY:   decay_curve   <= rnd24[23:0];
          SEG_RELEASE: release_curve <= rnd24[23:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Segment select and envelope value
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      seg  <= SEG_ATTACK;
      over <= 1'b0;
    end else if (state == S_CHECK) begin
      over <= note_over;
      // attack wins over an early gate
      if (sample_count < attack_samples) begin
        seg <= SEG_ATTACK;
      end else if (sample_count < gate_samples) begin
        seg <= SEG_DECAY;
      end else begin
        seg <= SEG_RELEASE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ENV_SET) begin
      case (seg)
        SEG_ATTACK:  env <= {1'b0, CURVE_ONE - attack_curve};
        // zero factor means no decay: sit on sustain
        SEG_DECAY:   env <= (decay_factor == 24'd0) ? s24 : (s24 + rnd24[24:0]);
        // zero factor means instant cut
        SEG_RELEASE: env <= (release_factor == 24'd0) ? 25'd0 : rnd24[24:0];
        default:     env <= '0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Harmonic loop: fetch sine, multiply by weight, accumulate
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      hidx <= '0;
      s1_v <= 1'b0;
      p_v  <= 1'b0;
    end else begin
      s1_v <= sine_load;
      p_v  <= (state == S_HARM) && s1_v;
      if (state == S_CHECK) begin
        hidx <= '0;
      end else if (sine_load) begin
        hidx <= hidx + HIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    p_neg <= sine.neg;
    if (state == S_CHECK) begin
      // phase * k built by adding 2 * phase per odd harmonic
      ph_acc <= phase;
      ph_two <= {phase[30:0], 1'b0};
      acc    <= '0;
    end else begin
      if (sine_load) begin
        ph_acc <= ph_acc + ph_two;
        s1_amp <= AMP_ROM[hidx[AIDX_W-1:0]];
      end
      if (p_v) begin
        if (p_neg) begin
          acc <= acc - $signed({1'b0, mul_p[ACC_W-2:0]});
        end else begin
          acc <= acc + $signed({1'b0, mul_p[ACC_W-2:0]});
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output scaling: sign-magnitude, envelope, full scale, clip
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      S_ABS: begin
        neg <= acc[ACC_W-1];
        mag <= acc[ACC_W-1] ? 32'(-acc) : 32'(acc);
      end
      S_SCALE_SET: mag2       <= rnd24[31:0];
      S_FS_SET:    res_sample <= sat_sample;
      default: ;
    endcase
  end

  // Output register: hold the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      sample   <= over ? 16'sd0 : $signed(res_sample);
      done_res <= over;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASV_ASSERT_NEXT(a_accept_check, clk, rst, accept, state == S_CHECK,
                   "accepted tick did not start the sequence")
  `ASV_ASSERT_NOW(a_all_harm, clk, rst, state == S_ABS, hidx == HIDX_W'(NUM_HARM),
                  "harmonic loop ended early")
  `ASV_ASSERT_NOW(a_done_silent, clk, rst, out_valid && done_res, sample == 16'sd0,
                  "finished note gave a nonzero sample")
  `ASV_ASSERT_NEXT(a_fin_hold, clk, rst, state == S_FIN && out_valid && out_stall,
                   state == S_FIN, "result dropped while output stalled")

endmodule

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the additive square voice, predicting each sample in place.
`timescale 1ns / 1ps

module testbench;
  import asvadsr_pkg::*;

  localparam int HALF        = 2;        // half clock period, ns
  localparam int RESET_LEN   = 11;
  localparam int ITEM_GOAL   = 1600;
  localparam int QUIET_GAP   = 45;       // margin for a sounding tick still in flight
  localparam int HOLD_LEN    = 400;      // receiver hold-off used to back the block up
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_CAP   = 40;
  localparam int QTR         = 1 << (SINE_TABLE_BITS - 2);

  typedef struct packed {
    logic signed [15:0] pcm;
    logic               done;
  } voice_out_t;

  // Bit-true model of the voice: tables, register copy, note state and the
  // samples still owed by the block.
  class voice_predictor;
    logic [31:0] step_r;
    logic [23:0] atk_len, atk_fac, dec_fac, gate_len, rel_fac, note_len;
    logic [15:0] sus_r;
    logic [23:0] t_count, atk_crv, dec_crv, rel_crv;
    logic [31:0] phase_acc;
    longint      sine_q [0:QTR];
    longint      weight [0:HARMONICS];
    voice_out_t  owed_samples [$];
    int          errors, checked, silent_ticks;

    function new();
      logic [63:0] u, x, x2, t, s, h;
      // quarter sine, Q1.15, from a Q28 odd Taylor series in nested form
      for (int i = 0; i <= QTR; i++) begin
        u = 64'(i) << (28 - (SINE_TABLE_BITS - 2));
        x = (u * 64'd421657428) >> 28;
        x2 = (x * x) >> 28;
        t = 64'd1 << 28;
        for (int n = 10; n >= 2; n -= 2) begin
          t = (64'd1 << 28) - ((x2 * t) >> 28) / 64'(n * (n + 1));
        end
        s = (x * t) >> 28;
        s = (s * 64'd32767 + (64'd1 << 27)) >> 28;
        sine_q[i] = (s > 64'd32767) ? 64'd32767 : s;
      end
      // 1/k weights for odd k, normalized to a Q0.16 sum of one
      h = 0;
      for (int k = 1; k <= HARMONICS; k += 2) h += (64'd1 << 32) / 64'(k);
      if (h == 0) h = 1;
      for (int k = 0; k <= HARMONICS; k++) weight[k] = 0;
      for (int k = 1; k <= HARMONICS; k += 2) begin
        weight[k] = ((((64'd1 << 32) / 64'(k)) << 16) + h / 2) / h;
      end
      step_r = 32'd39370534;
      atk_len = 24'd480;
      atk_fac = 24'd16603360;
      dec_fac = 24'd16765569;
      sus_r = 16'd16384;
      gate_len = 24'd33600;
      rel_fac = 24'd16771392;
      note_len = 24'd48000;
      t_count = '0;
      phase_acc = '0;
      atk_crv = '1;
      dec_crv = '1;
      rel_crv = '1;
      errors = 0;
      checked = 0;
      silent_ticks = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [31:0] v);
      case (idx)
        CFG_PHASE_STEP:     step_r = v;
        CFG_ATTACK_SAMPLES: atk_len = v[23:0];
        CFG_ATTACK_FACTOR:  atk_fac = v[23:0];
        CFG_DECAY_FACTOR:   dec_fac = v[23:0];
        CFG_SUSTAIN_LEVEL:  sus_r = v[15:0];
        CFG_GATE_SAMPLES:   gate_len = v[23:0];
        CFG_RELEASE_FACTOR: rel_fac = v[23:0];
        CFG_NOTE_SAMPLES:   note_len = v[23:0];
        default: ;
      endcase
    endfunction

    function logic [23:0] next_curve(logic [23:0] c, logic [23:0] f);
      return 24'((64'(c) * 64'(f) + (64'd1 << 23)) >> 24);
    endfunction

    function longint sine_of(logic [31:0] p);
      logic [SINE_TABLE_BITS-1:0] idx;
      logic [SINE_TABLE_BITS-3:0] r;
      longint v;
      idx = p[31 -: SINE_TABLE_BITS];
      r = idx[SINE_TABLE_BITS-3:0];
      v = idx[SINE_TABLE_BITS-2] ? sine_q[QTR - r] : sine_q[r];
      return idx[SINE_TABLE_BITS-1] ? -v : v;
    endfunction

    function int pending();
      return owed_samples.size();
    endfunction

    // Work out the sample for one accepted tick and queue it.
    function void take_tick(logic r);
      voice_out_t  o;
      logic [63:0] env, sus24, mag;
      longint      acc;
      if (r) begin
        t_count = '0;
        phase_acc = '0;
        atk_crv = '1;
        dec_crv = '1;
        rel_crv = '1;
      end
      if (t_count >= note_len) begin
        o.pcm = '0;
        o.done = 1'b1;
        silent_ticks++;
      end else begin
        sus24 = 64'((sus_r > 16'd32768) ? 16'd32768 : sus_r) << 9;
        if (t_count < atk_len) begin
          env = 64'(24'hFFFFFF - atk_crv);
          atk_crv = next_curve(atk_crv, atk_fac);
        end else if (t_count < gate_len) begin
          if (dec_fac == 0) env = sus24;
          else env = sus24 + ((((64'd1 << 24) - sus24) * 64'(dec_crv) + (64'd1 << 23)) >> 24);
          dec_crv = next_curve(dec_crv, dec_fac);
        end else begin
          if (rel_fac == 0) env = 0;
          else env = (sus24 * 64'(rel_crv) + (64'd1 << 23)) >> 24;
          rel_crv = next_curve(rel_crv, rel_fac);
        end
        acc = 0;
        for (int k = 1; k <= HARMONICS; k += 2) begin
          acc += weight[k] * sine_of(phase_acc * 32'(k));
        end
        mag = (acc < 0) ? 64'(-acc) : 64'(acc);
        mag = (mag * env + (64'd1 << 23)) >> 24;
        mag = (mag * ((64'd1 << (SAMPLE_BITS - 1)) - 1) + (64'd1 << 30)) >> 31;
        if (acc < 0) begin
          if (mag > 64'd32768) mag = 64'd32768;
          o.pcm = 16'(64'd0 - mag);
        end else begin
          if (mag > 64'd32767) mag = 64'd32767;
          o.pcm = mag[15:0];
        end
        o.done = 1'b0;
        t_count = t_count + 24'd1;
        phase_acc = phase_acc + step_r;
      end
      owed_samples.push_back(o);
    endfunction

    task report(string what);
      if (errors < PRINT_CAP) $display("MISMATCH @%0t: %s", $time, what);
      errors++;
    endtask

    task match_sample(logic signed [15:0] s, logic d);
      voice_out_t w;
      if (owed_samples.size() == 0) begin
        report($sformatf("sample %0d done=%0b with no tick waiting", s, d));
        return;
      end
      w = owed_samples.pop_front();
      checked++;
      if (s !== w.pcm) report($sformatf("sample got %0d, want %0d", s, w.pcm));
      if (d !== w.done) report($sformatf("done_res got %0b, want %0b", d, w.done));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid, in_stall, restart;
  logic               out_valid, out_stall, done_res;
  logic signed [15:0] sample;
  logic               cfg_valid, cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;

  voice_predictor voice;
  logic [31:0]    reg_val [8];
  logic           quiet;      // both sides stop idling while set
  logic           hold_req;   // ask the receiver for one long hold-off
  int             items, reg_loads, cycles;

  additive_square_voice_with_adsr_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .restart   (restart),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample),
    .done_res  (done_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF clk = ~clk;

  // Watchdog: abort the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Check every sample result taken by the sink at the rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) voice.match_sample(sample, done_res);
  end

  // Sink: stall at random, or hold off for a counted stretch when asked.
  initial begin : sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 7);
      end
    end
  end

  // Offer one tick request; return at the falling edge after it is taken.
  task automatic send_tick(input logic r);
    if (!quiet && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 60);
    end
    in_valid <= 1'b1;
    restart <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    voice.take_tick(r);
    items++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed sample has come back.
  task automatic await_samples();
    in_valid <= 1'b0;
    while (voice.pending() != 0) @(negedge clk);
  endtask

  // Drain, then give the block time to finish any tick still in flight.
  task automatic settle_block();
    await_samples();
    repeat (QUIET_GAP) @(negedge clk);
  endtask

  task automatic set_all(input logic [31:0] step, input logic [23:0] atk, input logic [23:0] af,
                         input logic [23:0] df, input logic [15:0] sus, input logic [23:0] gate,
                         input logic [23:0] rf, input logic [23:0] note);
    reg_val[CFG_PHASE_STEP]     = step;
    reg_val[CFG_ATTACK_SAMPLES] = 32'(atk);
    reg_val[CFG_ATTACK_FACTOR]  = 32'(af);
    reg_val[CFG_DECAY_FACTOR]   = 32'(df);
    reg_val[CFG_SUSTAIN_LEVEL]  = 32'(sus);
    reg_val[CFG_GATE_SAMPLES]   = 32'(gate);
    reg_val[CFG_RELEASE_FACTOR] = 32'(rf);
    reg_val[CFG_NOTE_SAMPLES]   = 32'(note);
  endtask

  // Write all eight registers, one config request each, back to back.
  task automatic load_regs();
    for (int i = CFG_PHASE_STEP; i <= CFG_NOTE_SAMPLES; i++) begin
      cfg_index <= 3'(i);
      cfg_data <= reg_val[i];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      voice.set_reg(cfg_reg_t'(i), reg_val[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    reg_loads++;
  endtask

  // Envelope multiplier: mostly slow curves near one, plus the extremes.
  function automatic logic [23:0] pick_factor();
    case ($urandom_range(9))
      0:       return 24'd0;
      1:       return 24'hFFFFFF;
      2, 3:    return 24'($urandom);
      default: return 24'hFFFFFF - 24'($urandom_range(0, 1 << 19));
    endcase
  endfunction

  // Short notes so that attack, decay, release and note end all come up.
  task automatic pick_settings();
    logic [23:0] note, atk, gate;
    logic [15:0] sus;
    logic [31:0] step;
    note = ($urandom_range(11) == 0) ? 24'd0 : 24'($urandom_range(1, 40));
    atk = 24'($urandom_range(0, note));
    gate = 24'($urandom_range(0, note));
    if ($urandom_range(9) == 0) atk = 24'hFFFFFF;
    if ($urandom_range(9) == 0) gate = 24'hFFFFFF;
    if ($urandom_range(15) == 0) note = 24'hFFFFFF;
    case ($urandom_range(9))
      0:       sus = 16'd0;
      1:       sus = 16'd32768;
      2:       sus = 16'($urandom_range(32769, 65535));
      default: sus = 16'($urandom_range(0, 32768));
    endcase
    case ($urandom_range(9))
      0:       step = 32'd0;
      1:       step = 32'hFFFFFFFF;
      2, 3:    step = $urandom_range(1, 1 << 24);
      default: step = $urandom;
    endcase
    set_all(step, atk, pick_factor(), pick_factor(), sus, gate, pick_factor(), note);
    // fill the data bits above each register's width; the block must drop them
    if ($urandom_range(3) == 0) begin
      reg_val[CFG_ATTACK_SAMPLES][31:24] = 8'($urandom);
      reg_val[CFG_ATTACK_FACTOR][31:24]  = 8'($urandom);
      reg_val[CFG_DECAY_FACTOR][31:24]   = 8'($urandom);
      reg_val[CFG_SUSTAIN_LEVEL][31:16]  = 16'($urandom);
      reg_val[CFG_GATE_SAMPLES][31:24]   = 8'($urandom);
      reg_val[CFG_RELEASE_FACTOR][31:24] = 8'($urandom);
      reg_val[CFG_NOTE_SAMPLES][31:24]   = 8'($urandom);
    end
  endtask

  // Play notes: a restart, the note body and a few ticks past its end; notes over 60 ticks are cut short.
  // A small share of notes skip the restart or get one mid-note.
  task automatic play_notes(input int budget);
    int n, len;
    len = int'(reg_val[CFG_NOTE_SAMPLES][23:0]);
    while (budget > 0) begin
      n = ((len > 60) ? 60 : len) + $urandom_range(1, 4);
      send_tick($urandom_range(9) != 0);
      for (int j = 1; j < n; j++) send_tick($urandom_range(99) < 3);
      budget -= n;
    end
  endtask

  initial begin : stimulus
    int phase_no;
    rst = 1'b1;
    in_valid = 1'b0;
    restart = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_PHASE_STEP;
    cfg_data = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    items = 0;
    reg_loads = 0;
    cycles = 0;
    voice = new();
    repeat (RESET_LEN) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: first ticks run from the reset state, then a restart.
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);

    // Gate before attack end, sustain above full, flat attack factor,
    // release with a factor of one from a clamped sustain, then note end.
    settle_block();
    set_all(32'hFFFFFFFF, 24'd2, 24'hFFFFFF, 24'd0, 16'hFFFF, 24'd1, 24'hFFFFFF, 24'd6);
    load_regs();
    send_tick(1'b1);
    repeat (7) send_tick(1'b0);

    // Zero note length: every tick is past the end.
    settle_block();
    set_all(32'd0, 24'd0, 24'd0, 24'hFFFFFF, 16'd0, 24'hFFFFFF, 24'hFFFFFF, 24'd0);
    load_regs();
    send_tick(1'b1);
    send_tick(1'b0);

    // No decay at full sustain, instant release cut, restart right at note end.
    settle_block();
    set_all(32'h04000001, 24'd1, 24'd0, 24'd0, 16'd32768, 24'd4, 24'd0, 24'd7);
    load_regs();
    send_tick(1'b1);
    repeat (6) send_tick(1'b0);
    send_tick(1'b1);

    // Random settings, one block of notes per setting.
    for (phase_no = 0; items < ITEM_GOAL; phase_no++) begin
      settle_block();
      pick_settings();
      load_regs();
      quiet = (phase_no == 5);
      if (phase_no == 8) hold_req = 1'b1;
      if (phase_no == 3) begin
        play_notes(40);
        await_samples();
        play_notes(40);
      end else begin
        play_notes(80);
      end
    end
    quiet = 1'b0;

    await_samples();
    repeat (QUIET_GAP) @(negedge clk);
    $display("Ran %0d tick requests (%0d past note end) over %0d register settings.",
             items, voice.silent_ticks, reg_loads);
    $display("Compared %0d samples, %0d mismatches.", voice.checked, voice.errors);
    if (voice.errors == 0 && voice.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
